@@ rtl/dcrm_pkg.sv @@
package dcrm_pkg;

  // Time stamps, elapsed times and periods are this wide and wrap modulo 2^TIME_W.
  localparam int TIME_W     = 32;
  localparam int CNT_W      = $clog2(TIME_W);
  localparam int PERIOD_W   = 32;

  // Rate result and the constant dividend of the rate division.
  localparam int RATE_W     = 20;
  localparam int DIV_CNT_W  = $clog2(RATE_W);
  localparam logic [RATE_W-1:0] RATE_SCALE = RATE_W'(1000000);

  // Configuration register widths and reset values.
  localparam int THR_W      = 8;
  localparam int STALL_W    = 16;
  localparam int INTERVAL_W = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [THR_W-1:0]      THRESHOLD_RESET = THR_W'(5);
  localparam logic [STALL_W-1:0]    STALL_RESET     = STALL_W'(3000);
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET  = INTERVAL_W'(50);

  // Register indexes on the configuration channel.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_STALL     = 2'd1,
    REG_INTERVAL  = 2'd2
  } cfg_reg_t;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SERIAL,
    S_DIVIDE,
    S_DONE
  } state_t;

  // Debounce status for the current item.
  typedef struct packed {
    logic level;
    logic fell;
  } deb_t;

  // Comparison results gathered during the serial pass over the time words.
  typedef struct packed {
    logic gt_cap;     // elapsed > captured period
    logic gt_stall;   // elapsed > stall timeout
    logic el_gt_k;    // elapsed > rate scale
    logic cap_gt_k;   // captured period > rate scale
    logic el_nz;      // elapsed is nonzero
    logic cap_nz;     // captured period is nonzero
  } ser_flags_t;

  // Period as reported: saturates when the time word is wider than the field.
  function automatic logic [PERIOD_W-1:0] sat_period(input logic [TIME_W-1:0] v);
    logic [TIME_W-1:0] upper;
    upper = v >> PERIOD_W;
    if (upper != '0) begin
      return '1;
    end
    return PERIOD_W'(v);
  endfunction

endpackage

@@ rtl/dcrm_if.sv @@
// Sample channel: one raw level per item.
interface dcrm_in_if;
  import dcrm_pkg::*;
  logic valid;
  logic ready;
  logic raw_level;

  modport source (output valid, output raw_level, input ready);
  modport sink   (input valid, input raw_level, output ready);
endinterface

// Result channel: one result item per sample item.
interface dcrm_out_if;
  import dcrm_pkg::*;
  logic                valid;
  logic                ready;
  logic                clean_level;
  logic                falling_edge;
  logic [PERIOD_W-1:0] period_ms;
  logic [RATE_W-1:0]   rate_millihertz;
  logic                rate_updated;

  modport source (output valid, output clean_level, output falling_edge, output period_ms,
                  output rate_millihertz, output rate_updated, input ready);
  modport sink   (input valid, input clean_level, input falling_edge, input period_ms,
                  input rate_millihertz, input rate_updated, output ready);
endinterface

// Configuration write channel.
interface dcrm_cfg_if;
  import dcrm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/dcrm_debounce.sv @@
module dcrm_debounce (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic                       raw_level,
  input  logic [dcrm_pkg::THR_W-1:0] threshold,
  output dcrm_pkg::deb_t             deb
);
  import dcrm_pkg::*;

  logic [THR_W-1:0] integrator;
  logic [THR_W-1:0] integrator_next;
  logic             level;
  logic             level_next;
  logic             fell;

  // Up/down integrator with hysteresis: the level only moves at the ends of the range.
  always_comb begin
    integrator_next = integrator;
    level_next      = level;
    if (!raw_level) begin
      if (integrator < threshold) begin
        integrator_next = integrator + THR_W'(1);
      end else begin
        level_next = 1'b1;
      end
    end else begin
      if (integrator != '0) begin
        integrator_next = integrator - THR_W'(1);
      end else begin
        level_next = 1'b0;
      end
    end
  end

  // The state advances once per accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      integrator <= '0;
      level      <= 1'b0;
      fell       <= 1'b0;
    end else if (step) begin
      integrator <= integrator_next;
      level      <= level_next;
      fell       <= level & ~level_next;
    end
  end

  assign deb.level = level;
  assign deb.fell  = fell;

endmodule

@@ rtl/dcrm_serial.sv @@
module dcrm_serial (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          fell,
  input  logic [dcrm_pkg::STALL_W-1:0]  stall_timeout,
  output dcrm_pkg::ser_flags_t          flags,
  output logic [dcrm_pkg::RATE_W-1:0]   divisor,
  output logic [dcrm_pkg::PERIOD_W-1:0] period,
  output logic                          done
);
  import dcrm_pkg::*;

  // Time words rotate right one bit per cycle, least significant bit first.
  logic [TIME_W-1:0]  tick_q;
  logic [TIME_W-1:0]  edge_q;
  logic [TIME_W-1:0]  cap_q;
  logic [TIME_W-1:0]  el_q;
  logic [STALL_W-1:0] stall_sr;
  logic [RATE_W-1:0]  k_sr;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic               borrow;
  logic               carry;
  ser_flags_t         flags_next;

  logic t_bit;
  logic e_bit;
  logic d_bit;
  logic borrow_next;
  logic el_bit;
  logic cap_bit;
  logic edge_bit;
  logic tick_bit;
  logic carry_next;
  logic last;

  // One bit of time - edge, the period capture, the time increment and the compares.
  always_comb begin
    t_bit       = tick_q[0];
    e_bit       = edge_q[0];
    d_bit       = t_bit ^ e_bit ^ borrow;
    borrow_next = (~t_bit & e_bit) | (~(t_bit ^ e_bit) & borrow);
    el_bit      = fell ? 1'b0 : d_bit;
    cap_bit     = fell ? d_bit : cap_q[0];
    edge_bit    = fell ? t_bit : e_bit;
    tick_bit    = t_bit ^ carry;
    carry_next  = t_bit & carry;
    last        = (cnt == CNT_W'(TIME_W - 1));

    // A higher bit that differs overrides what the lower bits decided.
    flags_next          = flags;
    flags_next.gt_cap   = (el_bit != cap_bit)     ? el_bit  : flags.gt_cap;
    flags_next.gt_stall = (el_bit != stall_sr[0]) ? el_bit  : flags.gt_stall;
    flags_next.el_gt_k  = (el_bit != k_sr[0])     ? el_bit  : flags.el_gt_k;
    flags_next.cap_gt_k = (cap_bit != k_sr[0])    ? cap_bit : flags.cap_gt_k;
    flags_next.el_nz    = flags.el_nz | el_bit;
    flags_next.cap_nz   = flags.cap_nz | cap_bit;
  end

  // Control of the pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy & last;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Time state, reset to zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_q <= '0;
      edge_q <= '0;
      cap_q  <= '0;
    end else if (busy) begin
      tick_q <= {tick_bit, tick_q[TIME_W-1:1]};
      edge_q <= {edge_bit, edge_q[TIME_W-1:1]};
      cap_q  <= {cap_bit, cap_q[TIME_W-1:1]};
    end
  end

  // Working registers of the pass.
  always_ff @(posedge clk) begin
    if (start) begin
      borrow   <= 1'b0;
      carry    <= 1'b1;
      stall_sr <= stall_timeout;
      k_sr     <= RATE_SCALE;
      flags    <= '0;
    end else if (busy) begin
      borrow   <= borrow_next;
      carry    <= carry_next;
      stall_sr <= {1'b0, stall_sr[STALL_W-1:1]};
      k_sr     <= {1'b0, k_sr[RATE_W-1:1]};
      flags    <= flags_next;
      el_q     <= {el_bit, el_q[TIME_W-1:1]};
    end
  end

  assign divisor = flags.gt_cap ? RATE_W'(el_q) : RATE_W'(cap_q);
  assign period  = sat_period(cap_q);

endmodule

@@ rtl/dcrm_div.sv @@
module dcrm_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [dcrm_pkg::RATE_W-1:0] divisor,
  output logic [dcrm_pkg::RATE_W-1:0] quotient,
  output logic                        done
);
  import dcrm_pkg::*;

  logic [RATE_W-1:0]    dvd;
  logic [RATE_W-1:0]    rem;
  logic [RATE_W-1:0]    dsr;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [RATE_W:0]      trial;
  logic [RATE_W:0]      diff;
  logic                 q_bit;
  logic                 last;

  // Restoring step: bring down one dividend bit and try to subtract.
  always_comb begin
    trial = {rem, dvd[RATE_W-1]};
    diff  = trial - {1'b0, dsr};
    q_bit = ~diff[RATE_W];
    last  = (cnt == DIV_CNT_W'(RATE_W - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy & last;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DIV_CNT_W'(1);
        if (last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Quotient bits shift in most significant first.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= RATE_SCALE;
      rem      <= '0;
      dsr      <= divisor;
      quotient <= '0;
    end else if (busy) begin
      dvd      <= {dvd[RATE_W-2:0], 1'b0};
      rem      <= q_bit ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
      quotient <= {quotient[RATE_W-2:0], q_bit};
    end
  end

endmodule

@@ rtl/debounced_cadence_rate_meter.sv @@
// Channel   | Dir | Fields                                                        | Handshake
// samples   | in  | raw_level                                                     | valid/ready
// results   | out | clean_level, falling_edge, period_ms, rate_millihertz,
//           |     | rate_updated                                                  | valid/ready
// cfg       | in  | index, data (0 threshold, 1 stall timeout, 2 calc interval)   | valid/ready
//
// Each item runs the bit-serial pass over the time words and, when a rate is computed, the
// restoring divider, which gives one quotient bit per cycle. One item is in work at a time.
// Reset (rst, synchronous) clears the time state, the debounce, the rate and loads the
// register reset values. The result register lets a new item be accepted while the last
// result waits; a stalled result holds the block before it writes the next one.
module debounced_cadence_rate_meter (
  input logic         clk,
  input logic         rst,
  dcrm_in_if.sink     samples,
  dcrm_out_if.source  results,
  dcrm_cfg_if.sink    cfg
);
  import dcrm_pkg::*;

  state_t state;
  state_t state_next;

  logic [THR_W-1:0]      threshold;
  logic [STALL_W-1:0]    stall_timeout;
  logic [INTERVAL_W-1:0] calc_interval;
  logic [INTERVAL_W-1:0] calc_countdown;
  logic                  do_calc;
  logic [RATE_W-1:0]     rate_value;

  logic                  accept;
  logic                  in_ready;
  logic                  div_start;
  logic                  rate_clear;
  logic                  rate_load;
  logic                  out_load;
  logic                  out_valid;
  logic                  rate_zero;

  deb_t                  deb;
  ser_flags_t            flags;
  logic [RATE_W-1:0]     divisor;
  logic [PERIOD_W-1:0]   period;
  logic                  ser_done;
  logic [RATE_W-1:0]     quotient;
  logic                  div_done;

  assign accept     = samples.valid & in_ready;
  assign cfg.ready  = 1'b1;

  // Stalled, zero or too large divisors all give a rate of zero.
  assign rate_zero = flags.gt_stall | ~(flags.el_nz | flags.cap_nz) |
                     (flags.gt_cap ? flags.el_gt_k : flags.cap_gt_k);

  dcrm_debounce u_debounce (
    .clk       (clk),
    .rst       (rst),
    .step      (accept),
    .raw_level (samples.raw_level),
    .threshold (threshold),
    .deb       (deb)
  );

  dcrm_serial u_serial (
    .clk           (clk),
    .rst           (rst),
    .start         (accept),
    .fell          (deb.fell),
    .stall_timeout (stall_timeout),
    .flags         (flags),
    .divisor       (divisor),
    .period        (period),
    .done          (ser_done)
  );

  dcrm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (divisor),
    .quotient (quotient),
    .done     (div_done)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold     <= THRESHOLD_RESET;
      stall_timeout <= STALL_RESET;
      calc_interval <= INTERVAL_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_THRESHOLD: threshold     <= cfg.data[THR_W-1:0];
        REG_STALL:     stall_timeout <= cfg.data[STALL_W-1:0];
        REG_INTERVAL:  calc_interval <= cfg.data[INTERVAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (samples.valid) begin
          state_next = S_SERIAL;
        end
      end
      S_SERIAL: begin
        if (ser_done) begin
          state_next = (do_calc && !rate_zero) ? S_DIVIDE : S_DONE;
        end
      end
      S_DIVIDE: begin
        if (div_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || results.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Controls decoded from the state.
  always_comb begin
    in_ready   = 1'b0;
    div_start  = 1'b0;
    rate_clear = 1'b0;
    rate_load  = 1'b0;
    out_load   = 1'b0;
    case (state)
      S_IDLE:   in_ready = 1'b1;
      S_SERIAL: begin
        div_start  = ser_done & do_calc & ~rate_zero;
        rate_clear = ser_done & do_calc & rate_zero;
      end
      S_DIVIDE: rate_load = div_done;
      S_DONE:   out_load  = ~out_valid | results.ready;
      default: ;
    endcase
  end

  assign samples.ready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Countdown between rate computations; an interval of zero acts as one.
  always_ff @(posedge clk) begin
    if (rst) begin
      calc_countdown <= '0;
      do_calc        <= 1'b0;
    end else if (accept) begin
      do_calc <= (calc_countdown == '0);
      if (calc_countdown == '0) begin
        calc_countdown <= (calc_interval == '0) ? '0 : calc_interval - INTERVAL_W'(1);
      end else begin
        calc_countdown <= calc_countdown - INTERVAL_W'(1);
      end
    end
  end

  // Held rate value.
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_value <= '0;
    end else if (rate_clear) begin
      rate_value <= '0;
    end else if (rate_load) begin
      rate_value <= quotient;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      results.clean_level     <= deb.level;
      results.falling_edge    <= deb.fell;
      results.period_ms       <= period;
      results.rate_millihertz <= rate_value;
      results.rate_updated    <= do_calc;
    end
  end

  assign results.valid = out_valid;

endmodule

@@ rtl/dcrm_chk.sv @@
module dcrm_chk (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        clean_level,
  input logic                        falling_edge,
  input logic [dcrm_pkg::RATE_W-1:0] rate_millihertz
);
  import dcrm_pkg::*;

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  // One item at a time: an accepted item closes the input for the next cycle.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in work");

  // A falling edge leaves the clean level low.
  a_edge_low: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(falling_edge && clean_level))
    else $error("falling edge reported with high level");

  // The rate never exceeds the scale.
  a_rate_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> rate_millihertz <= RATE_SCALE)
    else $error("rate out of range");

endmodule

bind debounced_cadence_rate_meter dcrm_chk u_chk (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (samples.valid),
  .in_ready        (samples.ready),
  .out_valid       (results.valid),
  .out_ready       (results.ready),
  .clean_level     (results.clean_level),
  .falling_edge    (results.falling_edge),
  .rate_millihertz (results.rate_millihertz)
);

@@ tb/tb.sv @@
module tb;
  import dcrm_pkg::*;

  // Index past the end of the register list; writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // Window of accepted items during which neither side idles.
  localparam int CALM_FIRST = 1000;
  localparam int CALM_LAST  = 1250;

  // One expected result item.
  typedef struct packed {
    logic                level;
    logic                fell;
    logic [PERIOD_W-1:0] period;
    logic [RATE_W-1:0]   rate;
    logic                updated;
  } meter_reading_t;

  logic clk;
  logic rst;

  dcrm_in_if  samples_if ();
  dcrm_out_if results_if ();
  dcrm_cfg_if cfg_if ();

  debounced_cadence_rate_meter u_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if),
    .results (results_if),
    .cfg     (cfg_if)
  );

  // Raw samples waiting to be sent and readings waiting to come back.
  logic           raw_samples [$];
  meter_reading_t readings_due [$];

  int n_queued;
  int n_accepted;
  int n_checked;
  int n_errors;

  // Predicted register contents.
  logic [THR_W-1:0]      c_thr;
  logic [STALL_W-1:0]    c_stall;
  logic [INTERVAL_W-1:0] c_interval;

  // Predicted meter state.
  logic [TIME_W-1:0]     m_time;
  logic [THR_W-1:0]      m_integ;
  logic                  m_level;
  logic                  m_level_prev;
  logic [TIME_W-1:0]     m_edge;
  logic [TIME_W-1:0]     m_period;
  logic [INTERVAL_W-1:0] m_countdown;
  logic [RATE_W-1:0]     m_rate;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = ~clk;
  end

  // Random idling, switched off for a stretch in the middle of the run.
  function automatic bit roll_idle(input int count);
    if (count >= CALM_FIRST && count < CALM_LAST) begin
      return 1'b0;
    end
    return $urandom_range(0, 99) < 32;
  endfunction

  // Advance the predicted meter by one tick and queue the reading it gives.
  task automatic advance_meter(input logic raw);
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] divisor;
    logic [63:0]       wide_period;
    meter_reading_t    r;
    t = m_time;
    r = '0;

    // Integrating debounce with hysteresis; a low raw level means interrupted.
    if (!raw) begin
      if (m_integ < c_thr) begin
        m_integ = m_integ + 1'b1;
      end else begin
        m_level = 1'b1;
      end
    end else begin
      if (m_integ > 0) begin
        m_integ = m_integ - 1'b1;
      end else begin
        m_level = 1'b0;
      end
    end

    // Capture the period on a falling edge of the clean level.
    if (m_level_prev != m_level && !m_level) begin
      m_period = t - m_edge;
      m_edge   = t;
      r.fell   = 1'b1;
    end
    m_level_prev = m_level;

    // Periodic rate computation; a zero interval behaves as one.
    if (m_countdown == 0) begin
      elapsed = t - m_edge;
      if (elapsed > TIME_W'(c_stall)) begin
        m_rate = '0;
      end else begin
        divisor = (elapsed > m_period) ? elapsed : m_period;
        m_rate  = (divisor == 0) ? '0 : RATE_W'(64'(RATE_SCALE) / 64'(divisor));
      end
      m_countdown = (c_interval != 0) ? c_interval - 1'b1 : '0;
      r.updated   = 1'b1;
    end else begin
      m_countdown = m_countdown - 1'b1;
    end

    m_time = t + 1'b1;

    // The reported period saturates when time words are wider than the field.
    wide_period = 64'(m_period);
    r.period = (wide_period > 64'hFFFF_FFFF) ? '1 : PERIOD_W'(m_period);
    r.level  = m_level;
    r.rate   = m_rate;
    readings_due.push_back(r);
  endtask

  task automatic push_sample(input logic raw);
    raw_samples.push_back(raw);
    n_queued++;
  endtask

  // Wait until every queued sample has come back as a reading, then let the block settle.
  task automatic wait_drained();
    @(negedge clk);
    while (n_checked != n_queued) begin
      @(negedge clk);
    end
    repeat (60) @(posedge clk);
  endtask

  // Write one register over the configuration channel and track it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do begin
      @(posedge clk);
    end while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_THRESHOLD: c_thr      = data[THR_W-1:0];
      REG_STALL:     c_stall    = data[STALL_W-1:0];
      REG_INTERVAL:  c_interval = data[INTERVAL_W-1:0];
      default: ;
    endcase
  endtask

  // Rotations of the interrupter with contact bounce, noise bursts and occasional long
  // pauses that let the elapsed time run past the stall timeout.
  task automatic make_rotation(input int n, input int thr, input int pause_pct);
    int target;
    int run;
    int k;
    target = n_queued + n;
    while (n_queued < target) begin
      if ($urandom_range(0, 99) < 12) begin
        run = $urandom_range(1, 6);
        for (k = 0; k < run; k++) begin
          push_sample(1'($urandom));
        end
      end else begin
        run = $urandom_range(0, 3);
        for (k = 0; k < run; k++) begin
          push_sample(k[0]);
        end
        run = thr + 1 + $urandom_range(0, 6);
        for (k = 0; k < run; k++) begin
          push_sample(1'b0);
        end
        if ($urandom_range(0, 99) < pause_pct) begin
          run = $urandom_range(30, 400);
        end else begin
          run = thr + 1 + $urandom_range(0, 6);
        end
        for (k = 0; k < run; k++) begin
          push_sample(1'b1);
        end
      end
    end
  endtask

  // Sample driver: presents the next raw sample when the slot is free.
  always @(posedge clk) begin
    if (rst) begin
      samples_if.valid <= 1'b0;
    end else begin
      if (samples_if.valid && samples_if.ready) begin
        advance_meter(samples_if.raw_level);
        n_accepted++;
      end
      if (!samples_if.valid || samples_if.ready) begin
        if (raw_samples.size() > 0 && !roll_idle(n_accepted)) begin
          samples_if.valid     <= 1'b1;
          samples_if.raw_level <= raw_samples.pop_front();
        end else begin
          samples_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each accepted item against the oldest reading due.
  always @(posedge clk) begin
    if (rst) begin
      results_if.ready <= 1'b0;
    end else begin
      if (results_if.valid && results_if.ready) begin
        if (readings_due.size() == 0) begin
          $display({"%0t: result with no reading due:",
                    " level=%0b fell=%0b period=%0d rate=%0d upd=%0b"},
                   $time, results_if.clean_level, results_if.falling_edge,
                   results_if.period_ms, results_if.rate_millihertz, results_if.rate_updated);
          n_errors++;
        end else begin
          if (results_if.clean_level     !== readings_due[0].level  ||
              results_if.falling_edge    !== readings_due[0].fell   ||
              results_if.period_ms       !== readings_due[0].period ||
              results_if.rate_millihertz !== readings_due[0].rate   ||
              results_if.rate_updated    !== readings_due[0].updated) begin
            $display({"%0t: mismatch: expected level=%0b fell=%0b period=%0d rate=%0d upd=%0b,",
                      " actual level=%0b fell=%0b period=%0d rate=%0d upd=%0b"},
                     $time, readings_due[0].level, readings_due[0].fell,
                     readings_due[0].period, readings_due[0].rate, readings_due[0].updated,
                     results_if.clean_level, results_if.falling_edge, results_if.period_ms,
                     results_if.rate_millihertz, results_if.rate_updated);
            n_errors++;
          end
          void'(readings_due.pop_front());
        end
        n_checked++;
      end
      results_if.ready <= !roll_idle(n_checked);
    end
  end

  // Overall time limit.
  initial begin
    #(10 * 800000);
    $display("Some tests failed");
    $finish;
  end

  // Stimulus sequence.
  initial begin
    int thr;
    rst                  = 1'b1;
    samples_if.valid     = 1'b0;
    samples_if.raw_level = 1'b1;
    results_if.ready     = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = '0;
    cfg_if.data          = '0;
    n_queued             = 0;
    n_accepted           = 0;
    n_checked            = 0;
    n_errors             = 0;

    c_thr        = THRESHOLD_RESET;
    c_stall      = STALL_RESET;
    c_interval   = INTERVAL_RESET;
    m_time       = '0;
    m_integ      = '0;
    m_level      = 1'b0;
    m_level_prev = 1'b0;
    m_edge       = '0;
    m_period     = '0;
    m_countdown  = '0;
    m_rate       = '0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: the first tick computes with a zero divisor, then one full
    // interruption walks the integrator up to the threshold and back down.
    push_sample(1'b1);
    repeat (6) push_sample(1'b0);
    repeat (6) push_sample(1'b1);
    wait_drained();

    // No debounce and a rate every tick; upper data bits must be masked off and the
    // write past the register list must be dropped.
    write_reg(REG_THRESHOLD, 16'hAB00);
    write_reg(REG_INTERVAL, 16'hFC00);
    write_reg(REG_UNUSED, 16'h1234);
    push_sample(1'b0);
    push_sample(1'b1);
    push_sample(1'b0);
    push_sample(1'b1);
    push_sample(1'b1);
    push_sample(1'b0);
    push_sample(1'b0);
    push_sample(1'b1);
    push_sample(1'b1);
    push_sample(1'b1);
    wait_drained();

    // Zero stall timeout: any elapsed time past an edge reads as stalled.
    write_reg(REG_STALL, 16'h0000);
    push_sample(1'b0);
    push_sample(1'b1);
    push_sample(1'b1);
    push_sample(1'b0);
    push_sample(1'b1);
    wait_drained();

    // Random rotations with no debounce.
    make_rotation(40, 0, 10);
    wait_drained();

    // Short debounce, small timeout, short interval.
    thr = $urandom_range(1, 6);
    write_reg(REG_THRESHOLD, {8'($urandom), 8'(thr)});
    write_reg(REG_STALL, 16'($urandom_range(20, 300)));
    write_reg(REG_INTERVAL, {6'($urandom), 10'($urandom_range(1, 15))});
    make_rotation(220, thr, 15);
    wait_drained();

    // Largest settings throughout; one full rotation is about 520 items.
    write_reg(REG_THRESHOLD, 16'h00FF);
    write_reg(REG_STALL, 16'hFFFF);
    write_reg(REG_INTERVAL, 16'h03FF);
    make_rotation(200, 255, 0);
    wait_drained();

    // Random timeout over the full range.
    thr = $urandom_range(0, 10);
    write_reg(REG_THRESHOLD, {8'($urandom), 8'(thr)});
    write_reg(REG_STALL, 16'($urandom));
    write_reg(REG_INTERVAL, {6'($urandom), 10'($urandom_range(1, 40))});
    make_rotation(260, thr, 10);
    wait_drained();

    // Rate every tick with frequent stalls.
    thr = $urandom_range(2, 8);
    write_reg(REG_INTERVAL, 16'h0001);
    write_reg(REG_UNUSED, 16'($urandom));
    write_reg(REG_THRESHOLD, {8'($urandom), 8'(thr)});
    write_reg(REG_STALL, 16'($urandom_range(10, 120)));
    make_rotation(280, thr, 25);
    wait_drained();

    // Back to the reset settings.
    write_reg(REG_THRESHOLD, 16'(THRESHOLD_RESET));
    write_reg(REG_STALL, 16'(STALL_RESET));
    write_reg(REG_INTERVAL, 16'(INTERVAL_RESET));
    make_rotation(60, 5, 5);
    wait_drained();

    if (readings_due.size() != 0) begin
      $display("%0t: %0d readings never arrived", $time, readings_due.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
